@@ rtl/imu_arc_pkg.sv @@
`default_nettype none

package imu_arc_pkg;

  // Filter state width, fixed by the output range
  localparam int STATE_BITS = 28;
  // Unity weight of the filter, Q16
  localparam int ALPHA_ONE  = 65536;

  typedef enum logic [1:0] {
    REG_ROLL_OFFSET  = 2'd0,
    REG_PITCH_OFFSET = 2'd1,
    REG_DEADBAND     = 2'd2,
    REG_ALPHA_WEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_FIL,
    ST_OUT
  } seq_state_e;

  // Step strobes from the sequencer to every lane
  typedef struct packed {
    logic load;
    logic mul;
    logic rnd;
    logic fil;
    logic commit;
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/imu_arc_if.sv @@
`default_nettype none

interface imu_arc_in_if;
  logic                valid;
  logic                ready;
  logic                euler_ok;
  logic        [16:0]  heading_in;
  logic signed [16:0]  roll_in;
  logic signed [16:0]  pitch_in;
  logic signed [15:0]  gyro_x;
  logic signed [15:0]  gyro_y;
  logic signed [15:0]  gyro_z;

  modport source (
    output valid, euler_ok, heading_in, roll_in, pitch_in, gyro_x, gyro_y, gyro_z,
    input  ready
  );
  modport sink (
    input  valid, euler_ok, heading_in, roll_in, pitch_in, gyro_x, gyro_y, gyro_z,
    output ready
  );
endinterface

interface imu_arc_out_if;
  logic                valid;
  logic                ready;
  logic        [16:0]  heading_out;
  logic signed [16:0]  roll_out;
  logic signed [16:0]  pitch_out;
  logic signed [26:0]  rate_x;
  logic signed [26:0]  rate_y;
  logic signed [26:0]  rate_z;

  modport source (
    output valid, heading_out, roll_out, pitch_out, rate_x, rate_y, rate_z,
    input  ready
  );
  modport sink (
    input  valid, heading_out, roll_out, pitch_out, rate_x, rate_y, rate_z,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/imu_arc_angle_lane.sv @@
`default_nettype none

module imu_arc_angle_lane (
  input  wire                         clk_i,
  input  wire imu_arc_pkg::lane_ctrl_t ctrl_i,
  input  wire logic signed [16:0]     raw_i,
  input  wire logic signed [16:0]     offset_i,
  input  wire logic        [9:0]      deadband_i,
  output logic signed [16:0]          angle_o
);

  localparam logic signed [17:0] AngleLimit = 18'sd46080;
  localparam logic signed [17:0] AngleTurn  = 18'sd92160;

  logic signed [16:0] raw_q;
  logic signed [17:0] diff_q, diff_d;
  logic signed [16:0] angle_q, angle_d;
  logic signed [17:0] wrapped;
  logic        [16:0] mag;

  function automatic logic signed [16:0] sat_angle(input logic signed [16:0] v);
    logic signed [16:0] r;
    if (v > 17'sd46080) begin
      r = 17'sd46080;
    end else if (v < -17'sd46080) begin
      r = -17'sd46080;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign diff_d = 18'(sat_angle(raw_q)) - 18'(sat_angle(offset_i));

  // Wrap once into half a turn either side, then zero inside the deadband
  always_comb begin
    if (diff_q > AngleLimit) begin
      wrapped = diff_q - AngleTurn;
    end else if (diff_q < -AngleLimit) begin
      wrapped = diff_q + AngleTurn;
    end else begin
      wrapped = diff_q;
    end
    mag = wrapped[17] ? 17'(-wrapped) : 17'(wrapped);
    if (mag < 17'(deadband_i)) begin
      angle_d = '0;
    end else begin
      angle_d = 17'(wrapped);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      raw_q <= raw_i;
    end
    if (ctrl_i.mul) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.rnd) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

`default_nettype wire

@@ rtl/imu_arc_rate_lane.sv @@
`default_nettype none

module imu_arc_rate_lane #(
  parameter int RATE_FRAC_BITS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire imu_arc_pkg::lane_ctrl_t ctrl_i,
  input  wire logic signed [15:0]     gyro_i,
  input  wire logic        [16:0]     alpha_i,
  input  wire logic        [16:0]     beta_i,
  output logic signed [26:0]          rate_o
);

  localparam int SB    = imu_arc_pkg::STATE_BITS;
  localparam int Shift = 32 - RATE_FRAC_BITS;
  localparam int PW    = 44;
  localparam int RW    = PW - Shift;
  localparam int MW    = (RW > SB) ? RW : SB;
  localparam int SW    = MW + 19;
  // pi/180 in Q32
  localparam logic signed [27:0] Deg2Rad = 28'sd74961321;

  logic signed [15:0]    gyro_q;
  logic signed [PW-1:0]  prod_q, prod_d;
  logic        [PW-1:0]  prod_rnd;
  logic signed [RW-1:0]  rate_q;
  logic signed [RW+17:0] pa_q, pa_d;
  logic signed [SB+17:0] pb_q, pb_d;
  logic signed [SW-1:0]  sum;
  logic        [SW-1:0]  sum_rnd;
  logic signed [SB-1:0]  prev_q, y;

  assign prod_d = gyro_q * Deg2Rad;

  // Half away from zero: add half, less one for negative values, then floor
  assign prod_rnd = prod_q + PW'(64'd1 << (Shift - 1)) - PW'(prod_q[PW-1]);

  assign pa_d = $signed({1'b0, alpha_i}) * rate_q;
  assign pb_d = $signed({1'b0, beta_i}) * prev_q;

  assign sum     = SW'(pa_q) + SW'(pb_q);
  assign sum_rnd = sum + SW'(32768) - SW'(sum[SW-1]);
  assign y       = sum_rnd[SB+15:16];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      gyro_q <= gyro_i;
    end
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.rnd) begin
      rate_q <= prod_rnd[PW-1:Shift];
    end
    if (ctrl_i.fil) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (ctrl_i.commit) begin
      prev_q <= y;
    end
  end

  assign rate_o = y[26:0];

endmodule

`default_nettype wire

@@ rtl/imu_angle_rate_conditioner.sv @@
// An accepted item steps through MUL, RND, FIL and OUT; its result is registered
// at the output on commit, which waits while the last result is not taken. A new
// item is taken only in IDLE, after the four-step lane sequence (gyro product,
// rounding, filter products, sum). Items with euler_ok clear give no result.
// Reset: filter state clears to zero, offsets to 0, deadband to 5 and the
// filter weight to 6554; no result is pending.
`default_nettype none

module imu_angle_rate_conditioner #(
  parameter int RATE_FRAC_BITS = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  imu_arc_in_if.sink       in_i,
  imu_arc_out_if.source    out_o,
  input  wire              cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_wdata_i
);

  imu_arc_pkg::seq_state_e state_q, state_d;
  imu_arc_pkg::lane_ctrl_t ctrl;

  logic signed [16:0] roll_off_q, pitch_off_q;
  logic        [9:0]  deadband_q;
  logic        [16:0] alpha_q;
  logic        [16:0] alpha_sat, beta;

  logic               in_acc;
  logic               slot_free;
  logic        [16:0] heading_q;

  logic signed [16:0] roll_ang, pitch_ang;
  logic signed [26:0] rate_x, rate_y, rate_z;

  logic               out_vld_q;
  logic        [16:0] heading_out_q;
  logic signed [16:0] roll_out_q, pitch_out_q;
  logic signed [26:0] rate_x_q, rate_y_q, rate_z_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_off_q  <= '0;
      pitch_off_q <= '0;
      deadband_q  <= 10'd5;
      alpha_q     <= 17'd6554;
    end else if (cfg_we_i) begin
      unique case (imu_arc_pkg::cfg_idx_e'(cfg_idx_i))
        imu_arc_pkg::REG_ROLL_OFFSET:  roll_off_q  <= cfg_wdata_i;
        imu_arc_pkg::REG_PITCH_OFFSET: pitch_off_q <= cfg_wdata_i;
        imu_arc_pkg::REG_DEADBAND:     deadband_q  <= cfg_wdata_i[9:0];
        imu_arc_pkg::REG_ALPHA_WEIGHT: alpha_q     <= cfg_wdata_i;
      endcase
    end
  end

  // Clamp the weight to unity
  assign alpha_sat = (alpha_q > 17'(imu_arc_pkg::ALPHA_ONE)) ?
                     17'(imu_arc_pkg::ALPHA_ONE) : alpha_q;
  assign beta      = 17'(imu_arc_pkg::ALPHA_ONE) - alpha_sat;

  assign in_i.ready = (state_q == imu_arc_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !out_vld_q || out_o.ready;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imu_arc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      imu_arc_pkg::ST_IDLE: begin
        // drop items whose orientation read failed
        if (in_acc && in_i.euler_ok) begin
          state_d = imu_arc_pkg::ST_MUL;
        end
      end
      imu_arc_pkg::ST_MUL: state_d = imu_arc_pkg::ST_RND;
      imu_arc_pkg::ST_RND: state_d = imu_arc_pkg::ST_FIL;
      imu_arc_pkg::ST_FIL: state_d = imu_arc_pkg::ST_OUT;
      imu_arc_pkg::ST_OUT: begin
        if (slot_free) begin
          state_d = imu_arc_pkg::ST_IDLE;
        end
      end
      default: state_d = imu_arc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.load   = in_acc && in_i.euler_ok;
    ctrl.mul    = (state_q == imu_arc_pkg::ST_MUL);
    ctrl.rnd    = (state_q == imu_arc_pkg::ST_RND);
    ctrl.fil    = (state_q == imu_arc_pkg::ST_FIL);
    ctrl.commit = (state_q == imu_arc_pkg::ST_OUT) && slot_free;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      heading_q <= in_i.heading_in;
    end
  end

  // Lanes
  imu_arc_angle_lane u_roll (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .raw_i      (in_i.roll_in),
    .offset_i   (roll_off_q),
    .deadband_i (deadband_q),
    .angle_o    (roll_ang)
  );

  imu_arc_angle_lane u_pitch (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .raw_i      (in_i.pitch_in),
    .offset_i   (pitch_off_q),
    .deadband_i (deadband_q),
    .angle_o    (pitch_ang)
  );

  imu_arc_rate_lane #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_rate_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .gyro_i  (in_i.gyro_x),
    .alpha_i (alpha_sat),
    .beta_i  (beta),
    .rate_o  (rate_x)
  );

  imu_arc_rate_lane #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_rate_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .gyro_i  (in_i.gyro_y),
    .alpha_i (alpha_sat),
    .beta_i  (beta),
    .rate_o  (rate_y)
  );

  imu_arc_rate_lane #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_rate_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .gyro_i  (in_i.gyro_z),
    .alpha_i (alpha_sat),
    .beta_i  (beta),
    .rate_o  (rate_z)
  );

  // Merge the lane results into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.commit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      heading_out_q <= heading_q;
      roll_out_q    <= roll_ang;
      pitch_out_q   <= pitch_ang;
      rate_x_q      <= rate_x;
      rate_y_q      <= rate_y;
      rate_z_q      <= rate_z;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.heading_out = heading_out_q;
  assign out_o.roll_out    = roll_out_q;
  assign out_o.pitch_out   = pitch_out_q;
  assign out_o.rate_x      = rate_x_q;
  assign out_o.rate_y      = rate_y_q;
  assign out_o.rate_z      = rate_z_q;

`ifndef SYNTH
  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(ctrl.commit))
    else $error("result appeared without a commit step");

  a_load_starts_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |=> (state_q == imu_arc_pkg::ST_MUL))
    else $error("loaded item did not start the lane sequence");

  a_drop_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.euler_ok) |=> (state_q == imu_arc_pkg::ST_IDLE) && !$rose(out_vld_q))
    else $error("dropped item started work");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |=> out_vld_q)
    else $error("committed item not shown at the output");
`endif

endmodule

`default_nettype wire

@@ verif/imu_arc_conditioner_check.sv @@
module imu_arc_conditioner_check #(
  parameter int RATE_FRAC_BITS = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_wdata_i,
  imu_arc_in_if            sample_i,
  imu_arc_out_if           cond_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               accepted_o,
  output int               dropped_o,
  output int               results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     STATE_BITS  = imu_arc_pkg::STATE_BITS;
  localparam longint ALPHA_ONE   = imu_arc_pkg::ALPHA_ONE;
  localparam longint ANGLE_LIMIT = 46080;
  localparam longint ANGLE_TURN  = 92160;
  // pi/180 in Q32
  localparam longint DEG2RAD_Q32 = 74961321;

  typedef struct {
    logic        [16:0] heading;
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
    logic signed [26:0] rate_x;
    logic signed [26:0] rate_y;
    logic signed [26:0] rate_z;
  } cond_sample_t;

  cond_sample_t       due_samples_q[$];
  logic signed [16:0] roll_zero;
  logic signed [16:0] pitch_zero;
  logic        [9:0]  dead_band;
  logic        [16:0] alpha_w;
  longint             smooth_x;
  longint             smooth_y;
  longint             smooth_z;

  function automatic longint clamp_angle(longint v);
    if (v > ANGLE_LIMIT) return ANGLE_LIMIT;
    if (v < -ANGLE_LIMIT) return -ANGLE_LIMIT;
    return v;
  endfunction

  // Shift right, rounding half away from zero
  function automatic longint round_shift(longint v, int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (s - 1))) >> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [16:0] level_angle(logic signed [16:0] raw,
                                                     logic signed [16:0] zero);
    longint d;
    longint mag;
    d = clamp_angle(longint'(raw)) - clamp_angle(longint'(zero));
    if (d > ANGLE_LIMIT) d -= ANGLE_TURN;
    else if (d < -ANGLE_LIMIT) d += ANGLE_TURN;
    mag = (d < 0) ? -d : d;
    if (mag < longint'(dead_band)) d = 0;
    return d[16:0];
  endfunction

  function automatic longint smooth_rate(logic signed [15:0] gyro, longint prev);
    longint                    a;
    longint                    rate;
    longint                    sum;
    logic signed [STATE_BITS-1:0] kept;
    a = (longint'(alpha_w) > ALPHA_ONE) ? ALPHA_ONE : longint'(alpha_w);
    rate = round_shift(longint'(gyro) * DEG2RAD_Q32, 32 - RATE_FRAC_BITS);
    sum = a * rate + (ALPHA_ONE - a) * prev;
    // state wraps at its own width
    kept = STATE_BITS'(round_shift(sum, 16));
    return longint'(kept);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ERROR %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(string name, logic signed [26:0] got,
                             logic signed [26:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    cond_sample_t want;
    if (!rst_ni) begin
      roll_zero    = '0;
      pitch_zero   = '0;
      dead_band    = 10'd5;
      alpha_w      = 17'd6554;
      smooth_x     = 0;
      smooth_y     = 0;
      smooth_z     = 0;
      due_samples_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      accepted_o   = 0;
      dropped_o    = 0;
      results_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          imu_arc_pkg::REG_ROLL_OFFSET:  roll_zero  = cfg_wdata_i;
          imu_arc_pkg::REG_PITCH_OFFSET: pitch_zero = cfg_wdata_i;
          imu_arc_pkg::REG_DEADBAND:     dead_band  = cfg_wdata_i[9:0];
          imu_arc_pkg::REG_ALPHA_WEIGHT: alpha_w    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (sample_i.valid && sample_i.ready) begin
        if (sample_i.euler_ok) begin
          want.heading = sample_i.heading_in;
          want.roll    = level_angle(sample_i.roll_in, roll_zero);
          want.pitch   = level_angle(sample_i.pitch_in, pitch_zero);
          smooth_x     = smooth_rate(sample_i.gyro_x, smooth_x);
          smooth_y     = smooth_rate(sample_i.gyro_y, smooth_y);
          smooth_z     = smooth_rate(sample_i.gyro_z, smooth_z);
          want.rate_x  = smooth_x[26:0];
          want.rate_y  = smooth_y[26:0];
          want.rate_z  = smooth_z[26:0];
          due_samples_q.push_back(want);
          accepted_o++;
        end else begin
          dropped_o++;
        end
      end
      if (cond_i.valid && cond_i.ready) begin
        if (due_samples_q.size() == 0) begin
          report_mismatch("result with no sample waiting for it");
        end else begin
          want = due_samples_q.pop_front();
          check_field("heading_out", 27'(cond_i.heading_out), 27'(want.heading));
          check_field("roll_out", 27'(cond_i.roll_out), 27'(want.roll));
          check_field("pitch_out", 27'(cond_i.pitch_out), 27'(want.pitch));
          check_field("rate_x", cond_i.rate_x, want.rate_x);
          check_field("rate_y", cond_i.rate_y, want.rate_y);
          check_field("rate_z", cond_i.rate_z, want.rate_z);
          results_o++;
        end
      end
      pending_o = due_samples_q.size();
    end
  end

endmodule

@@ verif/imu_angle_rate_conditioner_tb.sv @@
module imu_angle_rate_conditioner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RATE_FRAC_BITS = 16;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_SAMPLES = 800;
  localparam int PHASES         = 8;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [1:0]         cfg_idx;
  logic [16:0]        cfg_wdata;
  int                 idle_pct;
  int                 stall_pct;
  int                 quiet_cycles = 0;
  int                 settings_used;
  int                 fail_count;
  int                 pending;
  int                 accepted;
  int                 dropped;
  int                 results;
  logic signed [16:0] roll_zero_now;
  logic signed [16:0] pitch_zero_now;

  imu_arc_in_if  sample_if ();
  imu_arc_out_if cond_if ();

  imu_angle_rate_conditioner #(
    .RATE_FRAC_BITS(RATE_FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (sample_if),
    .out_o       (cond_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  imu_arc_conditioner_check #(
    .RATE_FRAC_BITS(RATE_FRAC_BITS)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .sample_i     (sample_if),
    .cond_i       (cond_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .accepted_o   (accepted),
    .dropped_o    (dropped),
    .results_o    (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    cond_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: give up after a long stretch with no item moving on either side
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (cond_if.valid && cond_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t timeout: no item moved for %0d cycles", $time, quiet_cycles);
      $display("imu_angle_rate_conditioner_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(logic ok, logic [16:0] heading, logic [16:0] roll,
                             logic [16:0] pitch, logic [15:0] gx, logic [15:0] gy,
                             logic [15:0] gz);
    while ($urandom_range(99) < idle_pct) begin
      sample_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_if.valid      <= 1'b1;
    sample_if.euler_ok   <= ok;
    sample_if.heading_in <= heading;
    sample_if.roll_in    <= roll;
    sample_if.pitch_in   <= pitch;
    sample_if.gyro_x     <= gx;
    sample_if.gyro_y     <= gy;
    sample_if.gyro_z     <= gz;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the sender until every result is out, then let dropped items settle
  task automatic drain();
    sample_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(imu_arc_pkg::cfg_idx_e idx, logic [16:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(logic [16:0] roll_zero, logic [16:0] pitch_zero,
                               logic [9:0] band, logic [16:0] alpha);
    drain();
    write_reg(imu_arc_pkg::REG_ROLL_OFFSET, roll_zero);
    write_reg(imu_arc_pkg::REG_PITCH_OFFSET, pitch_zero);
    write_reg(imu_arc_pkg::REG_DEADBAND, {7'd0, band});
    write_reg(imu_arc_pkg::REG_ALPHA_WEIGHT, alpha);
    roll_zero_now  = roll_zero;
    pitch_zero_now = pitch_zero;
    settings_used++;
  endtask

  function automatic logic [16:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 17'd0;
      1:       return 17'(46080);
      2:       return 17'(-46080);
      3:       return 17'($urandom);
      default: return 17'($urandom_range(0, 92160) - 46080);
    endcase
  endfunction

  function automatic logic [9:0] pick_band();
    case ($urandom_range(0, 3))
      0:       return 10'd0;
      1:       return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [16:0] pick_alpha();
    case ($urandom_range(0, 7))
      0:       return 17'd0;
      1:       return 17'd1;
      2:       return 17'd65536;
      3:       return 17'h1FFFF;
      4:       return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [16:0] pick_heading();
    if ($urandom_range(0, 3) == 0) return 17'($urandom);
    return 17'($urandom_range(0, 92160));
  endfunction

  // Mostly in range; some raw bit patterns, some near the deadband, some at the wrap edge
  function automatic logic [16:0] pick_angle(logic signed [16:0] zero);
    int base;
    base = zero;
    if (base > 46080) base = 46080;
    if (base < -46080) base = -46080;
    case ($urandom_range(0, 9))
      6, 7:    return 17'($urandom);
      8:       return 17'(base + int'($urandom_range(0, 2200)) - 1100);
      9:       return 17'(($urandom_range(0, 1) ? 46080 : -46080)
                          + int'($urandom_range(0, 2)) - 1);
      default: return 17'($urandom_range(0, 92160) - 46080);
    endcase
  endfunction

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'(int'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int   good;
    logic ok;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = imu_arc_pkg::REG_ROLL_OFFSET;
    cfg_wdata            = '0;
    sample_if.valid      = 1'b0;
    sample_if.euler_ok   = 1'b0;
    sample_if.heading_in = '0;
    sample_if.roll_in    = '0;
    sample_if.pitch_in   = '0;
    sample_if.gyro_x     = '0;
    sample_if.gyro_y     = '0;
    sample_if.gyro_z     = '0;
    cond_if.ready        = 1'b0;
    idle_pct             = 0;
    stall_pct            = 0;
    settings_used        = 1;
    roll_zero_now        = '0;
    pitch_zero_now       = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting: zero offsets, deadband 5, default weight
    send_sample(1'b1, 17'd0, 17'd0, 17'd0, 16'd0, 16'd0, 16'd0);
    send_sample(1'b1, 17'd92160, 17'(46080), 17'(-46080), 16'h7FFF, 16'h8000, 16'd1);
    // heading above a full turn passes through; angles beyond range saturate
    send_sample(1'b1, 17'h1FFFF, 17'h0FFFF, 17'h10000, 16'hFFFF, 16'd1, 16'h8000);
    send_sample(1'b0, 17'h1FFFF, 17'(1000), 17'(-1000), 16'h7FFF, 16'h7FFF, 16'h7FFF);
    // just inside and just on the deadband edge
    send_sample(1'b1, 17'd12345, 17'd4, 17'(-5), 16'd100, 16'(-100), 16'd0);
    send_sample(1'b1, 17'd1, 17'(-4), 17'd5, 16'd0, 16'd0, 16'd0);

    apply_setting(17'(-46080), 17'(46080), 10'd0, 17'd65536);
    // full-turn difference wraps to zero; exactly half a turn stays
    send_sample(1'b1, 17'd100, 17'(46080), 17'(-46080), 16'd1, 16'hFFFF, 16'd0);
    send_sample(1'b1, 17'd200, 17'd0, 17'd0, 16'd0, 16'd0, 16'd0);
    send_sample(1'b1, 17'd300, 17'd1, 17'(-1), 16'h7FFF, 16'h8000, 16'd0);

    // offsets beyond range saturate; weight above unity acts as unity
    apply_setting(17'h0FFFF, 17'h10000, 10'd1023, 17'h1FFFF);
    send_sample(1'b1, 17'd400, 17'(-46080), 17'(46080), 16'h8000, 16'h7FFF, 16'h1234);
    send_sample(1'b1, 17'd500, 17'(45057), 17'(-45058), 16'h8000, 16'h7FFF, 16'h1234);
    send_sample(1'b1, 17'h10000, 17'(45056), 17'(-45057), 16'd7, 16'(-7), 16'd0);

    // zero weight holds the filter
    apply_setting(17'd0, 17'd0, 10'd5, 17'd0);
    send_sample(1'b1, 17'd600, 17'd10, 17'(-10), 16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(1'b0, 17'd0, 17'd0, 17'd0, 16'h8000, 16'h8000, 16'h8000);

    apply_setting(17'd0, 17'd0, 10'd5, 17'd1);
    send_sample(1'b1, 17'd700, 17'd20, 17'd30, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_sample(1'b1, 17'd800, 17'(-20), 17'(-30), 16'h8000, 16'h8000, 16'h7FFF);

    for (int phase = 0; phase < PHASES; phase++) begin
      apply_setting(pick_offset(), pick_offset(), pick_band(), pick_alpha());
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      good = 0;
      while (good < RANDOM_SAMPLES / PHASES) begin
        ok = ($urandom_range(0, 9) != 0);
        send_sample(ok, pick_heading(), pick_angle(roll_zero_now),
                    pick_angle(pitch_zero_now), pick_rate(), pick_rate(), pick_rate());
        if (ok) begin
          good++;
          if (good == 40) drain();
        end
      end
    end

    drain();
    $display("covered %0d conditioned and %0d dropped samples over %0d register settings",
             accepted, dropped, settings_used);
    $display("%0d results compared under four idling mixes", results);
    if (fail_count == 0 && pending == 0) begin
      $display("imu_angle_rate_conditioner_tb OK");
    end else begin
      $display("imu_angle_rate_conditioner_tb NOT OK");
    end
    $finish;
  end

endmodule
